@@ src/btc_pkg.sv @@
package btc_pkg;

  localparam int MAX_BLOCK_DEF = 16;
  localparam int PERM_W        = 4;
  localparam int PERM_ENTRIES  = 16;
  localparam int TABLE_W       = PERM_W * PERM_ENTRIES;
  localparam int LEN_W         = 5;
  localparam int BYTE_W        = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = TABLE_W;

  localparam logic [BYTE_W-1:0]     PAD_BYTE      = 8'h41;
  localparam logic [TABLE_W-1:0]    PERM_RESET    = 64'hFEDC_BA98_7654_3210;
  localparam logic [LEN_W-1:0]      LEN_RESET     = 5'd16;

  localparam logic [CFG_IDX_W-1:0]  CFG_PERM_TABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0]  CFG_BLOCK_LEN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0]  CFG_DECRYPT_MODE = 2'd2;

  typedef struct packed {
    logic store_wr;
    logic emit_ld;
    logic emit_done;
  } btc_cmd_t;

  typedef struct packed {
    logic flush;
    logic last_idx;
    logic out_free;
  } btc_sts_t;

endpackage

@@ src/block_transposition_cipher.sv @@
// Permutation cipher over a byte stream: bytes are collected into blocks of
// block_len bytes (0 acts as 1, values above MAX_BLOCK act as MAX_BLOCK), and
// each full block, or a partial one closed by end_of_message and padded with
// 0x41, is sent out as a run of block_len permuted bytes. Bytes are accepted
// one per cycle while idle, and none while a run is emitted. The limit is
// the single block buffer, which is filled and then read out one byte a
// cycle whenever the output register is free or out_ready is high. The
// output register lets the first byte of the next block be accepted while
// the last beat of a run still waits. Configuration must be written through
// cfg_we, cfg_idx and cfg_data only while idle, which the user must ensure.
module block_transposition_cipher #(
  parameter int MAX_BLOCK = btc_pkg::MAX_BLOCK_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [btc_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [btc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [btc_pkg::BYTE_W-1:0]      in_byte,
  input  logic                            in_end_of_message,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [btc_pkg::BYTE_W-1:0]      out_byte,
  output logic                            out_block_last,
  output logic                            out_message_last
);
  import btc_pkg::*;

  btc_cmd_t cmd;
  btc_sts_t sts;

  btc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  btc_dp #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_data          (cfg_data),
    .in_byte           (in_byte),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_block_last    (out_block_last),
    .out_message_last  (out_message_last),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule

@@ src/btc_ctrl.sv @@
module btc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  btc_pkg::btc_sts_t sts,
  output btc_pkg::btc_cmd_t cmd
);
  import btc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd.store_wr  = 1'b0;
    cmd.emit_ld   = 1'b0;
    cmd.emit_done = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.store_wr = in_valid;
        if (in_valid && sts.flush) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit_ld = sts.out_free;
        if (sts.out_free && sts.last_idx) begin
          cmd.emit_done = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ src/btc_dp.sv @@
module btc_dp #(
  parameter int MAX_BLOCK = btc_pkg::MAX_BLOCK_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [btc_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [btc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [btc_pkg::BYTE_W-1:0]      in_byte,
  input  logic                            in_end_of_message,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [btc_pkg::BYTE_W-1:0]      out_byte,
  output logic                            out_block_last,
  output logic                            out_message_last,
  input  btc_pkg::btc_cmd_t               cmd,
  output btc_pkg::btc_sts_t               sts
);
  import btc_pkg::*;

  localparam int IDX_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCK + 1);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_BLOCK);

  logic [TABLE_W-1:0] perm_r;
  logic [LEN_W-1:0]   blk_len_r;
  logic               decrypt_r;

  logic [BYTE_W-1:0]  store_r [MAX_BLOCK];
  logic [CNT_W-1:0]   fill_r;
  logic [IDX_W-1:0]   pos_r;
  logic               eom_r;

  logic               out_valid_r;
  logic [BYTE_W-1:0]  out_byte_r;
  logic               out_blast_r;
  logic               out_mlast_r;

  logic [CNT_W-1:0]   len_eff;
  logic [LEN_W-1:0]   len_ext;
  logic [LEN_W:0]     fill_inc;
  logic               src_hit;
  logic [IDX_W-1:0]   src_idx;
  logic [PERM_W-1:0]  dec_entry;
  logic [BYTE_W-1:0]  emit_byte;

  always_comb begin
    if (blk_len_r == '0) begin
      len_eff = CNT_W'(1);
    end else if (blk_len_r > MAX_LEN) begin
      len_eff = CNT_W'(MAX_BLOCK);
    end else begin
      len_eff = blk_len_r[CNT_W-1:0];
    end
  end

  assign len_ext  = LEN_W'(len_eff);
  assign fill_inc = (LEN_W+1)'(fill_r) + (LEN_W+1)'(1);

  always_comb begin
    src_hit   = 1'b0;
    src_idx   = '0;
    dec_entry = perm_r[PERM_W*pos_r +: PERM_W];
    if (decrypt_r) begin
      if (LEN_W'(dec_entry) < len_ext) begin
        src_hit = 1'b1;
        src_idx = dec_entry[IDX_W-1:0];
      end
    end else begin
      for (int k = MAX_BLOCK - 1; k >= 0; k--) begin
        if ((LEN_W'(k) < len_ext) && (perm_r[PERM_W*k +: PERM_W] == PERM_W'(pos_r))) begin
          src_hit = 1'b1;
          src_idx = IDX_W'(k);
        end
      end
    end
  end

  always_comb begin
    emit_byte = PAD_BYTE;
    if (src_hit && (CNT_W'(src_idx) < fill_r)) begin
      emit_byte = store_r[src_idx];
    end
  end

  assign sts.flush    = (fill_inc >= (LEN_W+1)'(len_ext)) || in_end_of_message;
  assign sts.last_idx = (CNT_W'(pos_r) + CNT_W'(1)) == len_eff;
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      perm_r    <= PERM_RESET;
      blk_len_r <= LEN_RESET;
      decrypt_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_PERM_TABLE:   perm_r    <= cfg_data;
        CFG_BLOCK_LEN:    blk_len_r <= cfg_data[LEN_W-1:0];
        CFG_DECRYPT_MODE: decrypt_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_wr) begin
      store_r[fill_r[IDX_W-1:0]] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      pos_r       <= '0;
      eom_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.store_wr) begin
        fill_r <= fill_inc[CNT_W-1:0];
        eom_r  <= in_end_of_message;
      end
      if (cmd.emit_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.emit_done) begin
        fill_r <= '0;
        pos_r  <= '0;
      end else if (cmd.emit_ld) begin
        pos_r  <= pos_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ld) begin
      out_byte_r  <= emit_byte;
      out_blast_r <= sts.last_idx;
      out_mlast_r <= sts.last_idx && eom_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_block_last   = out_blast_r;
  assign out_message_last = out_mlast_r;

endmodule
